[design/cvfe_pkg.sv]
// ----------------------------------------------------------------------------
// cvfe_pkg: shared constants for the channel varint frame encoder
// widths of the request fields, byte layout and queue sizing
// ----------------------------------------------------------------------------
package cvfe_pkg;

    localparam int CHAN_W         = 4;
    localparam int VALUE_W        = 49;
    localparam int BYTE_W         = 8;
    localparam int GROUP_BITS     = 7;
    localparam int COUNT_W        = 3;
    localparam int MAX_GROUPS_DEF = 7;

    // input tdata: channel then value, padded to whole bytes
    localparam int IN_FIELDS_W = CHAN_W + VALUE_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    // marker byte layout
    localparam logic MARK_BIT = 1'b1;
    localparam logic DATA_BIT = 1'b0;

    // descriptor queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

endpackage

[design/cvfe_front.sv]
// ----------------------------------------------------------------------------
// cvfe_front: request classifier
// counts the 7-bit groups of the value and builds the marker byte
// ----------------------------------------------------------------------------
module cvfe_front #(
    parameter int MAX_GROUPS = cvfe_pkg::MAX_GROUPS_DEF,
    parameter int GROUPS_W   = MAX_GROUPS * cvfe_pkg::GROUP_BITS
) (
    input  logic [cvfe_pkg::CHAN_W-1:0]  channel,
    input  logic [cvfe_pkg::VALUE_W-1:0] value,
    output logic [cvfe_pkg::BYTE_W-1:0]  marker,
    output logic [GROUPS_W-1:0]          groups
);

    logic [cvfe_pkg::COUNT_W-1:0] count;

    // one flag per group slot: any bit at or above the slot is set
    always_comb
    begin
        count = '0;
        for (int g = 0; g < MAX_GROUPS; g++)
        begin
            if (|(value >> (g * cvfe_pkg::GROUP_BITS)))
            begin
                count = count + cvfe_pkg::COUNT_W'(1);
            end
        end
    end

    assign marker = {cvfe_pkg::MARK_BIT, channel, count};
    // groups beyond the saturated count are dropped
    assign groups = value[GROUPS_W-1:0];

endmodule

[design/cvfe_queue.sv]
// ----------------------------------------------------------------------------
// cvfe_queue: short descriptor queue
// decouples request intake from byte emission
// ----------------------------------------------------------------------------
module cvfe_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic [DATA_W-1:0]           entry_reg [cvfe_pkg::QUEUE_DEPTH];
    logic [cvfe_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [cvfe_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [cvfe_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [cvfe_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [cvfe_pkg::QCNT_W-1:0] cnt_reg;
    logic [cvfe_pkg::QCNT_W-1:0] cnt_next;
    logic                        push;
    logic                        pop;

    assign in_ready  = (cnt_reg != cvfe_pkg::QCNT_W'(cvfe_pkg::QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + cvfe_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + cvfe_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + cvfe_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - cvfe_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cvfe_pkg::QCNT_W'(cvfe_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + cvfe_pkg::QCNT_W'(1)))
        else $error("queue count missed a push");
`endif

endmodule

[design/cvfe_back.sv]
// ----------------------------------------------------------------------------
// cvfe_back: byte sequencer
// emits the marker and then the groups, most significant first
// ----------------------------------------------------------------------------
module cvfe_back #(
    parameter int MAX_GROUPS = cvfe_pkg::MAX_GROUPS_DEF,
    parameter int GROUPS_W   = MAX_GROUPS * cvfe_pkg::GROUP_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  logic [cvfe_pkg::BYTE_W-1:0] q_marker,
    input  logic [GROUPS_W-1:0]         q_groups,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [cvfe_pkg::BYTE_W-1:0] out_byte,
    output logic                        out_marker,
    output logic                        out_last
);

    localparam int GB = cvfe_pkg::GROUP_BITS;

    logic [cvfe_pkg::COUNT_W-1:0] rem_reg;
    logic [cvfe_pkg::COUNT_W-1:0] rem_next;
    logic [cvfe_pkg::COUNT_W-1:0] idx;
    logic [GROUPS_W-1:0]          groups_reg;
    logic [GROUPS_W-1:0]          groups_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic [cvfe_pkg::BYTE_W-1:0]  byte_reg;
    logic [cvfe_pkg::BYTE_W-1:0]  byte_next;
    logic                         marker_reg;
    logic                         marker_next;
    logic                         last_reg;
    logic                         last_next;
    logic [GB-1:0]                sel;
    logic                         load;

    assign load    = !valid_reg || out_ready;
    assign q_ready = load && (rem_reg == '0);
    assign idx     = rem_reg - cvfe_pkg::COUNT_W'(1);

    // group at slot rem-1
    always_comb
    begin
        sel = '0;
        for (int g = 0; g < MAX_GROUPS; g++)
        begin
            if (cvfe_pkg::COUNT_W'(g) == idx)
            begin
                sel = groups_reg[g*GB +: GB];
            end
        end
    end

    always_comb
    begin
        rem_next    = rem_reg;
        groups_next = groups_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        marker_next = marker_reg;
        last_next   = last_reg;
        if (load)
        begin
            if (rem_reg != '0)
            begin
                valid_next  = 1'b1;
                byte_next   = {cvfe_pkg::DATA_BIT, sel};
                marker_next = 1'b0;
                last_next   = (rem_reg == cvfe_pkg::COUNT_W'(1));
                rem_next    = idx;
            end
            else if (q_valid)
            begin
                valid_next  = 1'b1;
                byte_next   = q_marker;
                marker_next = 1'b1;
                last_next   = (q_marker[cvfe_pkg::COUNT_W-1:0] == '0);
                rem_next    = q_marker[cvfe_pkg::COUNT_W-1:0];
                groups_next = q_groups;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        groups_reg <= groups_next;
        byte_reg   <= byte_next;
        marker_reg <= marker_next;
        last_reg   <= last_next;
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign out_marker = marker_reg;
    assign out_last   = last_reg;

`ifndef SYNTHESIS
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= cvfe_pkg::COUNT_W'(MAX_GROUPS))
        else $error("group counter beyond maximum");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && marker_reg) |->
            (byte_reg[cvfe_pkg::BYTE_W-1] && (last_reg == (byte_reg[2:0] == 3'b000))))
        else $error("marker byte and last flag disagree");

    a_group_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !marker_reg) |->
            (!byte_reg[cvfe_pkg::BYTE_W-1] && (last_reg == (rem_reg == '0))))
        else $error("data byte flagged wrongly");
`endif

endmodule

[design/channel_varint_frame_encoder.sv]
// ----------------------------------------------------------------------------
// channel_varint_frame_encoder: channel tagged varint frame encoder
// turns a channel and value request into a marker byte and 7-bit groups
// ----------------------------------------------------------------------------
//  channel  dir  tdata                          tuser      tlast
//  s_axis   in   [3:0] channel, [52:4] value    -          -
//  m_axis   out  [7:0] out_byte                 is_marker  last
//
// a request of n groups leaves as n+1 bytes, 1 to MAX_GROUPS+1, from the byte
// sequencer that emits one byte per cycle while m_axis is not stalled
// requests are taken every cycle while the two-entry descriptor queue has room
// the output register takes the next byte in the cycle its byte is taken
// rst_n clears the queue, the sequencer and the output valid at once
// a stall on m_axis fills the queue, then drops s_axis_tready
// ----------------------------------------------------------------------------
module channel_varint_frame_encoder #(
    parameter int MAX_GROUPS = cvfe_pkg::MAX_GROUPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [cvfe_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // channel[3:0], value[52:4], pad
    // bytes out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [cvfe_pkg::BYTE_W-1:0]     m_axis_tdata,  // out_byte[7:0]
    output logic                            m_axis_tuser,  // is_marker[0]
    output logic                            m_axis_tlast
);

    localparam int GROUPS_W = MAX_GROUPS * cvfe_pkg::GROUP_BITS;
    localparam int DESC_W   = cvfe_pkg::BYTE_W + GROUPS_W;

    logic [cvfe_pkg::CHAN_W-1:0]  req_channel;
    logic [cvfe_pkg::VALUE_W-1:0] req_value;
    logic [cvfe_pkg::BYTE_W-1:0]  fr_marker;
    logic [GROUPS_W-1:0]          fr_groups;
    logic [DESC_W-1:0]            q_out;
    logic                         q_valid;
    logic                         q_ready;

    // unpack the request fields, padding bits are ignored
    assign req_channel = s_axis_tdata[cvfe_pkg::CHAN_W-1:0];
    assign req_value   = s_axis_tdata[cvfe_pkg::IN_FIELDS_W-1:cvfe_pkg::CHAN_W];

    // front: group count and marker, combinational off the request
    cvfe_front #(
        .MAX_GROUPS (MAX_GROUPS),
        .GROUPS_W   (GROUPS_W)
    ) u_front (
        .channel (req_channel),
        .value   (req_value),
        .marker  (fr_marker),
        .groups  (fr_groups)
    );

    // descriptor queue: marker in the low byte, groups above
    cvfe_queue #(
        .DATA_W (DESC_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   ({fr_groups, fr_marker}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out)
    );

    // back: one byte per cycle into the output register while m_axis is not stalled
    cvfe_back #(
        .MAX_GROUPS (MAX_GROUPS),
        .GROUPS_W   (GROUPS_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_marker   (q_out[cvfe_pkg::BYTE_W-1:0]),
        .q_groups   (q_out[DESC_W-1:cvfe_pkg::BYTE_W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_marker (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for channel_varint_frame_encoder
// drives channel and value requests with random gaps, predicts the marker
// byte and the 7-bit groups of each request, and checks every byte that
// leaves m_axis against the oldest predicted byte, under random stalls
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAN_W         = cvfe_pkg::CHAN_W;
    localparam int VALUE_W        = cvfe_pkg::VALUE_W;
    localparam int BYTE_W         = cvfe_pkg::BYTE_W;
    localparam int GROUP_BITS     = cvfe_pkg::GROUP_BITS;
    localparam int MAX_GROUPS_DEF = cvfe_pkg::MAX_GROUPS_DEF;
    localparam int IN_TDATA_W     = cvfe_pkg::IN_TDATA_W;

    localparam int RANDOM_REQUESTS = 380;
    localparam int SETTLE_CYCLES   = 40;
    localparam int CYCLE_LIMIT     = 1000000;

    // one request as the sender sees it
    typedef struct {
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
    } varint_request_t;

    // one byte of an encoded frame
    typedef struct {
        logic [BYTE_W-1:0] out_byte;
        logic              is_marker;
        logic              is_last;
    } frame_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;   // channel[3:0], value[52:4], pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [BYTE_W-1:0]     m_axis_tdata;          // out_byte[7:0]
    logic                  m_axis_tuser;          // is_marker[0]
    logic                  m_axis_tlast;          // last

    varint_request_t pending_requests[$];
    frame_byte_t     frame_bytes_due[$];
    int              error_count = 0;
    int              cycle_count = 0;

    channel_varint_frame_encoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // frame prediction
    // ------------------------------------------------------------------------

    // count the 7-bit groups, then queue the marker and the groups, top first
    function automatic void encode_frame(input logic [CHAN_W-1:0] chan,
                                         input logic [VALUE_W-1:0] val);
        int          groups;
        frame_byte_t fb;
        logic [VALUE_W-1:0] shifted;
        groups = 0;
        while (groups < MAX_GROUPS_DEF && (val >> (GROUP_BITS * groups)) != '0)
            groups++;
        fb.out_byte  = {1'b1, chan, 3'(groups)};
        fb.is_marker = 1'b1;
        fb.is_last   = (groups == 0);
        frame_bytes_due.push_back(fb);
        for (int g = groups; g > 0; g--)
        begin
            shifted      = val >> (GROUP_BITS * (g - 1));
            fb.out_byte  = {1'b0, shifted[6:0]};
            fb.is_marker = 1'b0;
            fb.is_last   = (g == 1);
            frame_bytes_due.push_back(fb);
        end
    endfunction

    // ------------------------------------------------------------------------
    // gap lengths: mostly none or short, a few long, and now and then a
    // quiet stretch with no gaps at all
    // ------------------------------------------------------------------------
    function automatic int pick_gap(inout int quiet_left);
        int roll;
        int gap;
        gap = 0;
        if (quiet_left > 0)
            quiet_left--;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                quiet_left = $urandom_range(20, 80);
            else if (roll < 50)
                gap = 0;
            else if (roll < 85)
                gap = $urandom_range(1, 3);
            else if (roll < 97)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
        end
        return gap;
    endfunction

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    int in_gap_left = 0;
    int in_quiet    = 0;

    always @(posedge clk or negedge rst_n)
    begin
        varint_request_t       req;
        logic                  hold;
        logic                  next_valid;
        logic [IN_TDATA_W-1:0] next_data;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            in_gap_left   = 0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            next_data  = s_axis_tdata;
            hold       = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                // request taken: predict from what was on the bus
                encode_frame(s_axis_tdata[CHAN_W-1:0],
                             s_axis_tdata[CHAN_W +: VALUE_W]);
                hold = 1'b0;
            end
            if (!hold)
            begin
                next_valid = 1'b0;
                if (in_gap_left > 0)
                    in_gap_left--;
                else if (pending_requests.size() > 0)
                begin
                    req         = pending_requests.pop_front();
                    next_valid  = 1'b1;
                    next_data   = '0;
                    next_data[CHAN_W-1:0]       = req.channel;
                    next_data[CHAN_W +: VALUE_W] = req.value;
                    in_gap_left = pick_gap(in_quiet);
                end
            end
            s_axis_tvalid <= next_valid;
            s_axis_tdata  <= next_data;
        end
    end

    // ------------------------------------------------------------------------
    // byte monitor and checker, with random back pressure
    // ------------------------------------------------------------------------
    int out_stall_left = 0;
    int out_quiet      = 0;

    always @(posedge clk or negedge rst_n)
    begin
        frame_byte_t fb;
        logic        took;
        logic        next_ready;
        if (!rst_n)
        begin
            m_axis_tready  <= 1'b0;
            out_stall_left = 0;
        end
        else
        begin
            took = m_axis_tvalid && m_axis_tready;
            if (took)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $error("unexpected byte: out_byte %h is_marker %b last %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    error_count++;
                end
                else
                begin
                    fb = frame_bytes_due.pop_front();
                    if (m_axis_tdata !== fb.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", fb.out_byte, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tuser !== fb.is_marker)
                    begin
                        $error("is_marker: expected %b, got %b", fb.is_marker, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tlast !== fb.is_last)
                    begin
                        $error("last: expected %b, got %b", fb.is_last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            // stalls start right after a taken byte, so they land on every
            // position inside a frame
            if (out_stall_left > 0)
            begin
                out_stall_left--;
                next_ready = (out_stall_left == 0);
            end
            else if (took)
            begin
                out_stall_left = pick_gap(out_quiet);
                next_ready     = (out_stall_left == 0);
            end
            else
                next_ready = 1'b1;
            m_axis_tready <= next_ready;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("channel_varint_frame_encoder: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    function automatic void add_request(input logic [CHAN_W-1:0] chan,
                                        input logic [VALUE_W-1:0] val);
        varint_request_t req;
        req.channel = chan;
        req.value   = val;
        pending_requests.push_back(req);
    endfunction

    // random value that needs exactly the given number of groups
    function automatic logic [VALUE_W-1:0] value_of_groups(input int groups);
        logic [63:0]        raw;
        logic [VALUE_W-1:0] val;
        raw = {$urandom, $urandom};
        val = raw[VALUE_W-1:0];
        if (groups == 0)
            val = '0;
        else if (groups < MAX_GROUPS_DEF)
        begin
            val = val & ((VALUE_W'(1) << (GROUP_BITS * groups)) - 1);
            if ((val >> (GROUP_BITS * (groups - 1))) == '0)
                val[GROUP_BITS * (groups - 1) + $urandom_range(0, GROUP_BITS - 1)] = 1'b1;
        end
        else if ((val >> (GROUP_BITS * (groups - 1))) == '0)
            val[GROUP_BITS * (groups - 1) + $urandom_range(0, GROUP_BITS - 1)] = 1'b1;
        return val;
    endfunction

    initial
    begin
        logic [63:0] raw;
        int          groups;

        // directed: zero value gives a lone marker, on both channel extremes
        add_request(4'd0, '0);
        add_request(4'd15, '0);
        add_request(4'd5, 49'd1);
        add_request(4'd10, 49'h7F);
        add_request(4'd3, 49'h80);
        // group count boundaries: largest value of k groups, smallest of k+1
        for (int k = 2; k <= 6; k++)
        begin
            add_request(4'(k), (VALUE_W'(1) << (GROUP_BITS * k)) - 1);
            add_request(4'(15 - k), VALUE_W'(1) << (GROUP_BITS * k));
        end
        // full width, all seven groups, and alternating bit patterns
        add_request(4'd15, {VALUE_W{1'b1}});
        add_request(4'd0, {VALUE_W{1'b1}});
        add_request(4'd9, 49'h0_AAAA_AAAA_AAAA);
        add_request(4'd6, 49'h1_5555_5555_5555);

        // random: group count spread evenly, some fully random values
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                raw = {$urandom, $urandom};
                add_request(4'($urandom_range(0, 15)), raw[VALUE_W-1:0]);
            end
            else
            begin
                groups = $urandom_range(0, MAX_GROUPS_DEF);
                add_request(4'($urandom_range(0, 15)), value_of_groups(groups));
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: every request sent and every predicted byte seen, looked at
        // away from the rising edge so the driver and monitor have settled
        do
            @(negedge clk);
        while (pending_requests.size() > 0 || s_axis_tvalid || frame_bytes_due.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (frame_bytes_due.size() > 0)
        begin
            $error("%0d predicted bytes never arrived", frame_bytes_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("channel_varint_frame_encoder: match");
        else
            $display("channel_varint_frame_encoder: mismatch");
        $finish;
    end

endmodule
